### src/jrc_pkg.sv
// Shared types, codes and constants for the joystick to RC channel frame unit.
`default_nettype none
package jrc_pkg;

  // Parameter defaults
  localparam int AXIS_COUNT_DEF   = 10;
  localparam int BUTTON_COUNT_DEF = 20;
  localparam int HAT_COUNT_DEF    = 2;

  // Frame bytes and layout
  localparam logic [7:0]  START_BYTE   = 8'hC8;
  localparam logic [7:0]  LEN_BYTE     = 8'd26;
  localparam logic [7:0]  TYPE_BYTE    = 8'h16;
  localparam logic [10:0] CENTER_CH    = 11'd992;
  localparam logic [10:0] LOW_CH       = 11'd0;
  localparam logic [10:0] HIGH_CH      = 11'd1984;
  localparam int          PAYLOAD_BITS = 176;

  // Byte positions within the frame
  localparam logic [4:0] IDX_SYNC      = 5'd0;
  localparam logic [4:0] IDX_LEN       = 5'd1;
  localparam logic [4:0] IDX_TYPE      = 5'd2;
  localparam logic [4:0] IDX_FIRST_PAY = 5'd3;
  localparam logic [4:0] IDX_CHK       = 5'd25;

  // Axis conversion constants
  localparam logic [21:0] NORM_SCALE = 22'd100;
  localparam logic [15:0] AXIS_FULL  = 16'd32767;
  localparam logic [7:0]  NORM_MID   = 8'd100;
  // floor(248 * 2^21 / 25) + 1: idx * 248 / 25 as a multiply and shift
  localparam logic [24:0] CONV_MUL   = 25'd20803748;

  // Hat vertical codes
  localparam logic [7:0] HAT_UP   = 8'h01;
  localparam logic [7:0] HAT_DOWN = 8'hFF;

  typedef enum logic [1:0] {
    MODE_BUTTON,
    MODE_AXIS,
    MODE_HAT,
    MODE_TICK
  } mode_t;

  typedef enum logic [2:0] {
    SLOT_ROLL,
    SLOT_PITCH,
    SLOT_THR,
    SLOT_YAW,
    SLOT_AUX3
  } slot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STICK,
    ST_AUX,
    ST_FRAME
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       store;
    logic       snap;
    logic       conv_load;
    slot_t      conv_sel;
    logic       conv_write;
    logic       aux_fixed;
    logic       byte_load;
    logic [4:0] byte_idx;
  } jrc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_range;
  } jrc_stat_t;

endpackage
`default_nettype wire

### src/joystick_to_rc_channel_frame_unit.sv
// Top level of the joystick to RC channel frame unit.
//
// Takes one joystick event or frame tick per transfer on the event channel and
// sends a 26-byte RC channels frame (sync 0xC8, length, type 0x16, 22 bytes of
// sixteen 11-bit channels packed LSB first, XOR checksum) one byte per transfer
// on the frame channel, with last_byte marking the checksum. An axis event is
// accepted and then runs four stick conversions through one shared two-stage
// normalize/scale unit; a button or hat event is accepted and then runs the aux
// update and the aux3 conversion through the same unit; out-of-range events are
// accepted without any update. A tick snapshots the channels when accepted and
// then loads one byte whenever the output register is free; the next event is
// taken right after the last byte is loaded into the output register.
`default_nettype none
module joystick_to_rc_channel_frame_unit
  import jrc_pkg::*;
#(
  parameter int AXIS_COUNT   = AXIS_COUNT_DEF,
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEF,
  parameter int HAT_COUNT    = HAT_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               event_valid,
  output logic                    event_ready,
  input  wire logic [1:0]         mode,
  input  wire logic [7:0]         number,
  input  wire logic signed [15:0] value,
  output logic                    frame_valid,
  input  wire logic               frame_ready,
  output logic [7:0]              frame_byte,
  output logic                    last_byte
);

  jrc_cmd_t  cmd;
  jrc_stat_t stat;

  jrc_controller u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .mode        (mode),
    .stat        (stat),
    .cmd         (cmd),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready)
  );

  jrc_datapath #(
    .AXIS_COUNT   (AXIS_COUNT),
    .BUTTON_COUNT (BUTTON_COUNT),
    .HAT_COUNT    (HAT_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .number     (number),
    .value      (value),
    .cmd        (cmd),
    .stat       (stat),
    .frame_byte (frame_byte),
    .last_byte  (last_byte)
  );

  // A tick transfer stalls the event side while the frame goes out
  a_tick_blocks: assert property (@(posedge clk) disable iff (rst)
    event_valid && event_ready && (mode == MODE_TICK) |=> !event_ready)
    else $error("event accepted right after a frame tick");

  // The byte counter never runs past the checksum position
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    u_ctrl.cnt <= IDX_CHK)
    else $error("frame byte counter out of range");

  // A byte is loaded only while the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.byte_load |-> (!frame_valid || frame_ready))
    else $error("output byte overwritten before transfer");

endmodule
`default_nettype wire

### src/jrc_datapath.sv
// Datapath: joystick stores, channel conversion, frame packing and output register.
`default_nettype none
module jrc_datapath
  import jrc_pkg::*;
#(
  parameter int AXIS_COUNT   = AXIS_COUNT_DEF,
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEF,
  parameter int HAT_COUNT    = HAT_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [1:0]         mode,
  input  wire logic [7:0]         number,
  input  wire logic signed [15:0] value,
  input  wire jrc_cmd_t           cmd,
  output jrc_stat_t               stat,
  output logic [7:0]              frame_byte,
  output logic                    last_byte
);

  localparam int AW = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
  localparam int BW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int HW = (HAT_COUNT > 1) ? $clog2(HAT_COUNT) : 1;

  logic signed [15:0] axis_store [AXIS_COUNT];
  logic               button_store [BUTTON_COUNT];
  logic [7:0]         hat_vertical [HAT_COUNT];
  logic [10:0]        stick_ch [4];
  logic [10:0]        aux_ch [4];

  logic [7:0]         conv_idx;
  slot_t              conv_slot;
  logic [PAYLOAD_BITS-1:0] shift;
  logic [7:0]         chk;

  mode_t              mode_e;
  logic signed [16:0] conv_a;
  logic [16:0]        mag;
  logic [21:0]        prod100;
  logic [6:0]         q0;
  logic [6:0]         q;
  logic [15:0]        rem;
  logic [7:0]         idx_next;
  logic [32:0]        chan_prod;
  logic [10:0]        conv_ch;
  logic [10:0]        aux1_next;
  logic [10:0]        aux2_next;
  logic [10:0]        aux4_next;
  logic [7:0]         byte_next;
  logic               is_payload;

  assign mode_e = mode_t'(mode);

  // Range check of the event index
  always_comb begin
    case (mode_e)
      MODE_BUTTON: stat.in_range = (number < 8'(BUTTON_COUNT));
      MODE_AXIS:   stat.in_range = (number < 8'(AXIS_COUNT));
      MODE_HAT:    stat.in_range = (number < 8'(HAT_COUNT));
      default:     stat.in_range = 1'b1;
    endcase
  end

  // Store event values
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXIS_COUNT; i++) axis_store[i] <= '0;
      for (int i = 0; i < BUTTON_COUNT; i++) button_store[i] <= 1'b0;
      for (int i = 0; i < HAT_COUNT; i++) hat_vertical[i] <= '0;
    end else if (cmd.store) begin
      case (mode_e)
        MODE_BUTTON: button_store[number[BW-1:0]] <= (value == 16'sd1);
        MODE_AXIS:   axis_store[number[AW-1:0]] <= value;
        MODE_HAT:    hat_vertical[number[HW-1:0]] <= value[15:8];
        default: ;
      endcase
    end
  end

  // Select the conversion source; throttle is inverted
  always_comb begin
    case (cmd.conv_sel)
      SLOT_ROLL:  conv_a = 17'(axis_store[3]);
      SLOT_PITCH: conv_a = 17'(axis_store[4]);
      SLOT_THR:   conv_a = -17'(axis_store[1]);
      SLOT_YAW:   conv_a = 17'(axis_store[0]);
      SLOT_AUX3:  conv_a = 17'(axis_store[2]);
      default:    conv_a = '0;
    endcase
  end

  // Normalize: trunc(a * 100 / 32767) via shift and one correction, offset by 100
  always_comb begin
    mag      = conv_a[16] ? 17'(-conv_a) : 17'(conv_a);
    prod100  = 22'(mag) * NORM_SCALE;
    q0       = prod100[21:15];
    rem      = {1'b0, prod100[14:0]} + {9'd0, q0};
    q        = (rem >= AXIS_FULL) ? q0 + 7'd1 : q0;
    idx_next = conv_a[16] ? NORM_MID - {1'b0, q} : NORM_MID + {1'b0, q};
  end

  // Scale the registered index to 0..1984
  assign chan_prod = 33'(conv_idx) * 33'(CONV_MUL);
  assign conv_ch   = chan_prod[31:21];

  // Fixed aux levels from buttons and hat
  always_comb begin
    if (button_store[0])      aux1_next = LOW_CH;
    else if (button_store[1]) aux1_next = CENTER_CH;
    else if (button_store[2]) aux1_next = HIGH_CH;
    else                      aux1_next = CENTER_CH;
    if (button_store[3])      aux2_next = HIGH_CH;
    else if (button_store[4]) aux2_next = LOW_CH;
    else                      aux2_next = CENTER_CH;
    if (hat_vertical[0] == HAT_UP)        aux4_next = HIGH_CH;
    else if (hat_vertical[0] == HAT_DOWN) aux4_next = LOW_CH;
    else                                  aux4_next = CENTER_CH;
  end

  // Conversion stage register
  always_ff @(posedge clk) begin
    if (cmd.conv_load) begin
      conv_idx  <= idx_next;
      conv_slot <= cmd.conv_sel;
    end
  end

  // Channel registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        stick_ch[i] <= CENTER_CH;
        aux_ch[i]   <= CENTER_CH;
      end
    end else begin
      if (cmd.aux_fixed) begin
        aux_ch[0] <= aux1_next;
        aux_ch[1] <= aux2_next;
        aux_ch[3] <= aux4_next;
      end
      if (cmd.conv_write) begin
        if (conv_slot == SLOT_AUX3) aux_ch[2] <= conv_ch;
        else                        stick_ch[conv_slot[1:0]] <= conv_ch;
      end
    end
  end

  // Pick the next frame byte
  assign is_payload = (cmd.byte_idx >= IDX_FIRST_PAY) && (cmd.byte_idx < IDX_CHK);
  always_comb begin
    case (cmd.byte_idx)
      IDX_SYNC: byte_next = START_BYTE;
      IDX_LEN:  byte_next = LEN_BYTE;
      IDX_TYPE: byte_next = TYPE_BYTE;
      IDX_CHK:  byte_next = chk;
      default:  byte_next = shift[7:0];
    endcase
  end

  // Snapshot channels, advance the packer and hold the output byte
  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      shift <= {{8{CENTER_CH}}, aux_ch[3], aux_ch[2], aux_ch[1], aux_ch[0],
                stick_ch[3], stick_ch[2], stick_ch[1], stick_ch[0]};
      chk   <= TYPE_BYTE;
    end else if (cmd.byte_load && is_payload) begin
      shift <= {8'd0, shift[PAYLOAD_BITS-1:8]};
      chk   <= chk ^ shift[7:0];
    end
    if (cmd.byte_load) begin
      frame_byte <= byte_next;
      last_byte  <= (cmd.byte_idx == IDX_CHK);
    end
  end

endmodule
`default_nettype wire

### src/jrc_controller.sv
// Controller: sequences event updates, channel conversions and frame output.
`default_nettype none
module jrc_controller
  import jrc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       event_valid,
  output logic            event_ready,
  input  wire logic [1:0] mode,
  input  wire jrc_stat_t  stat,
  output jrc_cmd_t        cmd,
  output logic            frame_valid,
  input  wire logic       frame_ready
);

  state_t     state, state_next;
  logic [4:0] cnt, cnt_next;
  logic       frame_valid_next;
  logic       accept;
  logic       out_free;
  mode_t      mode_e;

  assign mode_e   = mode_t'(mode);
  assign accept   = event_valid && event_ready;
  assign out_free = !frame_valid || frame_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      frame_valid <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      frame_valid <= frame_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    event_ready      = 1'b0;
    cmd              = '0;
    cmd.conv_sel     = SLOT_ROLL;
    cmd.byte_idx     = cnt;
    frame_valid_next = frame_valid && !frame_ready;
    case (state)
      ST_IDLE: begin
        event_ready = 1'b1;
        cnt_next    = '0;
        if (accept) begin
          cmd.store = (mode_e != MODE_TICK) && stat.in_range;
          cmd.snap  = (mode_e == MODE_TICK);
          if (mode_e == MODE_TICK)     state_next = ST_FRAME;
          else if (!stat.in_range)     state_next = ST_IDLE;
          else if (mode_e == MODE_AXIS) state_next = ST_STICK;
          else                         state_next = ST_AUX;
        end
      end
      ST_STICK: begin
        // Convert the four sticks, one write trailing each load
        cmd.conv_load  = (cnt < 5'd4);
        cmd.conv_sel   = slot_t'(cnt[2:0]);
        cmd.conv_write = (cnt != 5'd0);
        cnt_next       = cnt + 5'd1;
        if (cnt == 5'd4) begin
          state_next = ST_IDLE;
          cnt_next   = '0;
        end
      end
      ST_AUX: begin
        cmd.conv_sel = SLOT_AUX3;
        if (cnt == 5'd0) begin
          cmd.conv_load = 1'b1;
          cmd.aux_fixed = 1'b1;
          cnt_next      = 5'd1;
        end else begin
          cmd.conv_write = 1'b1;
          cnt_next       = '0;
          state_next     = ST_IDLE;
        end
      end
      ST_FRAME: begin
        // Load one byte whenever the output register is free
        if (out_free) begin
          cmd.byte_load    = 1'b1;
          frame_valid_next = 1'b1;
          cnt_next         = cnt + 5'd1;
          if (cnt == IDX_CHK) begin
            state_next = ST_IDLE;
            cnt_next   = '0;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
        cnt_next   = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

### bench/jrc_frame_checker.sv
// Checker for the RC frame unit: tracks joystick events, predicts frame bytes and compares them.
module jrc_frame_checker
  import jrc_pkg::*;
#(
  parameter int AXIS_COUNT   = AXIS_COUNT_DEF,
  parameter int BUTTON_COUNT = BUTTON_COUNT_DEF,
  parameter int HAT_COUNT    = HAT_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               event_valid,
  input  logic               event_ready,
  input  logic [1:0]         mode,
  input  logic [7:0]         number,
  input  logic signed [15:0] value,
  input  logic               frame_valid,
  input  logic               frame_ready,
  input  logic [7:0]         frame_byte,
  input  logic               last_byte,
  output int                 mismatch_count,
  output int                 bytes_due
);

  localparam int RC_LOW     = 1000;
  localparam int RC_MID     = 1500;
  localparam int RC_HIGH    = 2000;
  localparam int RING_DEPTH = 64;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  frame_beat_t        beat_ring[RING_DEPTH];
  int                 wr_total = 0;
  int                 rd_total = 0;
  logic signed [15:0] axis_pos[AXIS_COUNT];
  logic               button_down[BUTTON_COUNT];
  logic [7:0]         hat_vert[HAT_COUNT];
  logic [10:0]        stick_ch[4];  // roll, pitch, throttle, yaw
  logic [10:0]        aux_ch[4];    // aux1..aux4
  int                 fails = 0;

  // Clamp an RC pulse width and scale it to the 11-bit channel range
  function automatic logic [10:0] rc_channel(int rc);
    int lim;
    int scaled;
    lim    = (rc < RC_LOW) ? RC_LOW : ((rc > RC_HIGH) ? RC_HIGH : rc);
    scaled = ((lim - RC_LOW) * 1984) / 1000;
    return scaled[10:0];
  endfunction

  // Map a signed stick position to a channel through the percent step
  function automatic logic [10:0] stick_channel(int pos);
    int norm;
    norm = (pos * 100) / 32767;
    return rc_channel(RC_MID + 5 * norm);
  endfunction

  // Rebuild the four aux channels from buttons, axis 2 and hat 0
  function automatic void refresh_aux();
    int rc;
    if (button_down[0]) rc = RC_LOW;
    else if (button_down[1]) rc = RC_MID;
    else if (button_down[2]) rc = RC_HIGH;
    else rc = RC_MID;
    aux_ch[0] = rc_channel(rc);
    if (button_down[3]) rc = RC_HIGH;
    else if (button_down[4]) rc = RC_LOW;
    else rc = RC_MID;
    aux_ch[1] = rc_channel(rc);
    aux_ch[2] = stick_channel(int'(axis_pos[2]));
    if (hat_vert[0] == HAT_UP) rc = RC_HIGH;
    else if (hat_vert[0] == HAT_DOWN) rc = RC_LOW;
    else rc = RC_MID;
    aux_ch[3] = rc_channel(rc);
  endfunction

  // Append one predicted byte to the ring
  function automatic void add_beat(logic [7:0] data, logic last);
    frame_beat_t beat;
    beat.data = data;
    beat.last = last;
    beat_ring[wr_total % RING_DEPTH] = beat;
    wr_total++;
  endfunction

  always @(posedge clk) begin : track
    frame_beat_t  want;
    logic [175:0] payload;
    logic [10:0]  ch[16];
    logic [7:0]   sum;
    if (rst) begin
      for (int i = 0; i < AXIS_COUNT; i++) axis_pos[i] = '0;
      for (int i = 0; i < BUTTON_COUNT; i++) button_down[i] = 1'b0;
      for (int i = 0; i < HAT_COUNT; i++) hat_vert[i] = '0;
      for (int i = 0; i < 4; i++) begin
        stick_ch[i] = CENTER_CH;
        aux_ch[i]   = CENTER_CH;
      end
      wr_total = 0;
      rd_total = 0;
    end else begin
      // Compare each frame transfer with the oldest predicted byte
      if (frame_valid && frame_ready) begin
        if (wr_total == rd_total) begin
          $error("frame_byte: no byte expected, got %0h", frame_byte);
          fails++;
        end else begin
          want = beat_ring[rd_total % RING_DEPTH];
          rd_total++;
          if (frame_byte !== want.data) begin
            $error("frame_byte: expected %0h, got %0h", want.data, frame_byte);
            fails++;
          end
          if (last_byte !== want.last) begin
            $error("last_byte: expected %0d, got %0d", want.last, last_byte);
            fails++;
          end
        end
      end

      // Update state on each event transfer, queue a frame on a tick
      if (event_valid && event_ready) begin
        case (mode)
          MODE_BUTTON: begin
            if (number < BUTTON_COUNT) begin
              button_down[number] = (value == 1);
              refresh_aux();
            end
          end
          MODE_AXIS: begin
            if (number < AXIS_COUNT) begin
              axis_pos[number] = value;
              stick_ch[0] = stick_channel(int'(axis_pos[3]));
              stick_ch[1] = stick_channel(int'(axis_pos[4]));
              stick_ch[2] = stick_channel(-int'(axis_pos[1]));
              stick_ch[3] = stick_channel(int'(axis_pos[0]));
            end
          end
          MODE_HAT: begin
            if (number < HAT_COUNT) begin
              hat_vert[number] = value[15:8];
              refresh_aux();
            end
          end
          default: begin
            for (int i = 0; i < 4; i++) begin
              ch[i]     = stick_ch[i];
              ch[4 + i] = aux_ch[i];
            end
            for (int i = 8; i < 16; i++) ch[i] = CENTER_CH;
            for (int i = 0; i < 16; i++) payload[i*11 +: 11] = ch[i];
            add_beat(START_BYTE, 1'b0);
            add_beat(LEN_BYTE, 1'b0);
            add_beat(TYPE_BYTE, 1'b0);
            sum = TYPE_BYTE;
            for (int k = 0; k < PAYLOAD_BITS / 8; k++) begin
              add_beat(payload[k*8 +: 8], 1'b0);
              sum ^= payload[k*8 +: 8];
            end
            add_beat(sum, 1'b1);
          end
        endcase
      end
    end
    mismatch_count <= fails;
    bytes_due      <= wr_total - rd_total;
  end

endmodule

### bench/tb.sv
// Testbench top for the RC frame unit: drives events and frame ready, reports the verdict.
module tb;
  import jrc_pkg::*;

  localparam int PHASE_ITEMS    = 108;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               event_valid = 1'b0;
  logic               event_ready;
  logic [1:0]         mode        = MODE_BUTTON;
  logic [7:0]         number      = 8'd0;
  logic signed [15:0] value       = 16'sd0;
  logic               frame_valid;
  logic               frame_ready = 1'b0;
  logic [7:0]         frame_byte;
  logic               last_byte;
  int                 mismatch_count;
  int                 bytes_due;
  int                 idle_cycles = 0;
  bit                 no_idle     = 1'b0;
  bit                 hold_request = 1'b0;

  always #5 clk = ~clk;

  joystick_to_rc_channel_frame_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .mode        (mode),
    .number      (number),
    .value       (value),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame_byte  (frame_byte),
    .last_byte   (last_byte)
  );

  jrc_frame_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .event_valid    (event_valid),
    .event_ready    (event_ready),
    .mode           (mode),
    .number         (number),
    .value          (value),
    .frame_valid    (frame_valid),
    .frame_ready    (frame_ready),
    .frame_byte     (frame_byte),
    .last_byte      (last_byte),
    .mismatch_count (mismatch_count),
    .bytes_due      (bytes_due)
  );

  // Abort when neither channel has made a transfer for too long
  always @(posedge clk) begin
    if (rst || (event_valid && event_ready) || (frame_valid && frame_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one event after a random gap and hold it until the transfer
  task automatic offer_event(input mode_t m, input logic [7:0] idx, input logic [15:0] word);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      event_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    event_valid <= 1'b1;
    mode        <= m;
    number      <= idx;
    value       <= word;
    @(negedge clk);
    while (!event_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Stop offering and wait until every predicted byte has come out
  task automatic drain_frames();
    event_valid <= 1'b0;
    @(posedge clk);
    while (bytes_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Draw one random event, mostly on indices that matter; flag ignored ones
  task automatic random_event(output bit counted);
    mode_t       m;
    logic [7:0]  idx;
    logic [15:0] word;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) m = MODE_TICK;
    else if (pick < 45) m = MODE_BUTTON;
    else if (pick < 75) m = MODE_AXIS;
    else m = MODE_HAT;
    word = 16'($urandom);
    case (m)
      MODE_BUTTON: begin
        idx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, BUTTON_COUNT_DEF - 1))
                                           : 8'($urandom_range(0, 4));
        if ($urandom_range(0, 3) != 0) word = 16'($urandom_range(0, 1));
      end
      MODE_AXIS: begin
        idx  = 8'($urandom_range(0, AXIS_COUNT_DEF - 1));
        pick = $urandom_range(0, 9);
        if (pick == 0) word = 16'h7FFF;
        else if (pick == 1) word = 16'h8000;
        else if (pick == 2) word = 16'h8001;
      end
      MODE_HAT: begin
        idx = 8'($urandom_range(0, HAT_COUNT_DEF - 1));
        case ($urandom_range(0, 3))
          0: word[15:8] = HAT_UP;
          1: word[15:8] = HAT_DOWN;
          2: word[15:8] = 8'h00;
          default: ;
        endcase
      end
      default: idx = 8'($urandom_range(0, 255));
    endcase
    // Sprinkle indices from the full byte range
    if (m != MODE_TICK && $urandom_range(0, 9) == 0) idx = 8'($urandom_range(0, 255));
    counted = (m == MODE_TICK) ||
              (m == MODE_BUTTON && idx < BUTTON_COUNT_DEF) ||
              (m == MODE_AXIS && idx < AXIS_COUNT_DEF) ||
              (m == MODE_HAT && idx < HAT_COUNT_DEF);
    offer_event(m, idx, word);
  endtask

  task automatic random_phase(input int items);
    int done;
    bit counted;
    done = 0;
    while (done < items) begin
      random_event(counted);
      if (counted) done++;
    end
  endtask

  // Take frame bytes after random gaps; hold off for a long stretch on request
  initial begin : frame_sink
    int gap;
    do @(posedge clk); while (rst);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (hold_request) begin
        frame_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else if (gap > 0) begin
        frame_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      frame_ready <= 1'b1;
      @(negedge clk);
      while (!frame_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Centered channels straight out of reset
    offer_event(MODE_TICK, 8'd0, 16'h0000);
    // Stick extremes, including the negated throttle at full negative
    offer_event(MODE_AXIS, 8'd0, 16'h7FFF);
    offer_event(MODE_AXIS, 8'd1, 16'h8000);
    offer_event(MODE_AXIS, 8'd3, 16'h8001);
    offer_event(MODE_AXIS, 8'd4, 16'hFEB6);
    // Axis 2 alone must not move aux3 yet
    offer_event(MODE_AXIS, 8'd2, 16'h7FFF);
    offer_event(MODE_AXIS, 8'd10, 16'h1234);
    offer_event(MODE_AXIS, 8'd255, 16'hFFFF);
    offer_event(MODE_TICK, 8'd255, 16'hFFFF);
    // Button priorities and a value other than one
    offer_event(MODE_BUTTON, 8'd0, 16'h0001);
    offer_event(MODE_BUTTON, 8'd2, 16'h0001);
    offer_event(MODE_BUTTON, 8'd3, 16'h0001);
    offer_event(MODE_BUTTON, 8'd4, 16'h0005);
    offer_event(MODE_TICK, 8'd0, 16'h0000);
    offer_event(MODE_BUTTON, 8'd0, 16'h0000);
    offer_event(MODE_BUTTON, 8'd19, 16'h0001);
    offer_event(MODE_BUTTON, 8'd20, 16'h0001);
    // Hat up, down, the other hat, and an index past the end
    offer_event(MODE_HAT, 8'd0, 16'h01FF);
    offer_event(MODE_TICK, 8'd0, 16'h0000);
    offer_event(MODE_HAT, 8'd0, 16'hFF00);
    offer_event(MODE_HAT, 8'd1, 16'h0100);
    offer_event(MODE_HAT, 8'd2, 16'h0100);
    offer_event(MODE_BUTTON, 8'd3, 16'hFFFF);
    offer_event(MODE_TICK, 8'd0, 16'h0000);
    drain_frames();

    // Random traffic with idling on both sides
    random_phase(PHASE_ITEMS);
    drain_frames();

    // Back-to-back transfers on both channels
    no_idle = 1'b1;
    random_phase(PHASE_ITEMS);
    no_idle = 1'b0;
    drain_frames();

    // Hold the frame side off while ticks keep arriving
    hold_request = 1'b1;
    repeat (4) offer_event(MODE_TICK, 8'd0, 16'h0000);
    random_phase(PHASE_ITEMS);
    drain_frames();

    if (mismatch_count == 0 && bytes_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
